>>> src/srec_pkg.sv
// shared types, constants and character decode functions for the s-record parser
// no dependencies; imported by every module of the parser
`default_nettype none

package srec_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 32;
   localparam int ADDR_PORT_BITS       = 32;
   localparam int LIMIT_BITS           = 33;
   localparam int COUNT_BITS           = 32;

   localparam logic [LIMIT_BITS-1:0] ROM_LIMIT_RESET = 33'd262144;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_UPPER_S = 8'h53;
   localparam logic [7:0] CH_LOWER_S = 8'h73;

   typedef enum logic [2:0] {
      PH_LINE,
      PH_TYPE,
      PH_COUNT,
      PH_ADDR,
      PH_DATA,
      PH_CHECK,
      PH_EOL
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_CHECK,
      KIND_RECORD,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       new_file;
   } item_type;

   typedef struct packed {
      kind_type                  kind;
      logic [ADDR_PORT_BITS-1:0] address;
      logic [7:0]                data;
      logic                      checksum_ok;
      logic [3:0]                record_type;
      logic [COUNT_BITS-1:0]     record_count;
      logic [LIMIT_BITS-1:0]     high_water;
   } result_type;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      hex_nibble = v[3:0];
   endfunction

   function automatic logic type_ok(input logic [7:0] c);
      type_ok = (c == 8'h30) || (c == 8'h31) || (c == 8'h32) || (c == 8'h33) ||
                (c == 8'h35) || (c == 8'h37) || (c == 8'h38) || (c == 8'h39);
   endfunction

   function automatic logic [2:0] addr_len(input logic [3:0] t);
      case (t)
         4'd1, 4'd9: begin
            addr_len = 3'd2;
         end
         4'd2, 4'd8: begin
            addr_len = 3'd3;
         end
         4'd3, 4'd7: begin
            addr_len = 3'd4;
         end
         default: begin
            addr_len = 3'd0;
         end
      endcase
   endfunction

endpackage

`default_nettype wire

>>> src/srec_in_stage.sv
// input register of the parser: holds one request transaction for the parse core
// depends on srec_pkg
`default_nettype none

module srec_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_ch,
   input  wire logic             req_new_file,
   input  wire logic             advance,
   output logic                  in_valid,
   output srec_pkg::item_type    item
);
   import srec_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.ch       <= req_ch;
         item_ff.new_file <= req_new_file;
      end
   end

   assign in_valid = valid_ff;
   assign item     = item_ff;

endmodule

`default_nettype wire

>>> src/srec_parse_core.sv
// parser state, rom limit register and per-character decode of one s-record character
// depends on srec_pkg
`default_nettype none

module srec_parse_core #(
   parameter int ADDRESS_BITS = srec_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [srec_pkg::LIMIT_BITS-1:0]    csr_write_data,
   input  wire logic                               step,
   input  wire srec_pkg::item_type                 item,
   output logic                                    res_valid,
   output srec_pkg::result_type                    result
);
   import srec_pkg::*;

   logic [LIMIT_BITS-1:0]     rom_limit_ff;
   phase_type                 phase_ff, phase_in;
   logic                      expect_high_ff, expect_high_in;
   logic [3:0]                upper_ff, upper_in;
   logic [3:0]                type_ff, type_in;
   logic [2:0]                bytes_left_ff, bytes_left_in;
   logic [7:0]                data_left_ff, data_left_in;
   logic [7:0]                sum_ff, sum_in;
   logic [ADDRESS_BITS-1:0]   shift_ff, shift_in;
   logic [ADDRESS_BITS-1:0]   write_ff, write_in;
   logic [COUNT_BITS-1:0]     records_ff, records_in;
   logic [ADDRESS_BITS:0]     max_ff, max_in;
   logic                      halted_ff, halted_in;

   logic                      active;
   logic                      is_space;
   logic                      is_s;
   logic                      is_hex;
   logic                      hex_phase;
   logic                      low_nibble;
   logic [3:0]                nib;
   logic [7:0]                byte_v;
   logic [7:0]                sum_add;
   logic [2:0]                alen;
   logic                      count_short;
   logic [7:0]                data_count;
   logic                      data_type;
   logic [ADDRESS_BITS:0]     next_addr;
   logic                      in_rom;
   logic [ADDRESS_BITS-1:0]   shift_next;
   logic                      ev_fail;
   logic                      ev_write;
   logic                      ev_check;
   logic                      ev_record;

   assign active     = step & ~item.new_file & ~halted_ff;
   assign is_space   = (item.ch == CH_LF) || (item.ch == CH_CR) ||
                       (item.ch == CH_SPACE) || (item.ch == CH_TAB);
   assign is_s       = (item.ch == CH_UPPER_S) || (item.ch == CH_LOWER_S);
   assign is_hex     = hex_ok(item.ch);
   assign nib        = hex_nibble(item.ch);
   assign hex_phase  = (phase_ff == PH_COUNT) || (phase_ff == PH_ADDR) ||
                       (phase_ff == PH_DATA) || (phase_ff == PH_CHECK);
   assign low_nibble = is_hex & ~expect_high_ff;
   assign byte_v     = {upper_ff, nib};
   assign sum_add    = sum_ff + byte_v;
   assign alen       = addr_len(type_ff);
   assign count_short = {1'b0, byte_v} < ({6'd0, alen} + 9'd1);
   assign data_count = byte_v - {5'd0, alen} - 8'd1;
   assign data_type  = (type_ff == 4'd1) || (type_ff == 4'd2) || (type_ff == 4'd3);
   assign next_addr  = (ADDRESS_BITS+1)'(write_ff) + (ADDRESS_BITS+1)'(1);
   assign in_rom     = LIMIT_BITS'(write_ff) < rom_limit_ff;
   assign shift_next = {shift_ff[ADDRESS_BITS-9:0], byte_v};

   assign ev_fail = active & (((phase_ff == PH_LINE) & ~is_space & ~is_s) |
                              ((phase_ff == PH_TYPE) & ~type_ok(item.ch)) |
                              (hex_phase & ~is_hex) |
                              ((phase_ff == PH_COUNT) & low_nibble & count_short));
   assign ev_write  = active & (phase_ff == PH_DATA) & low_nibble & data_type & in_rom;
   assign ev_check  = active & (phase_ff == PH_CHECK) & low_nibble;
   assign ev_record = active & (phase_ff == PH_EOL) & (item.ch == CH_LF);

   // next state
   always_comb begin
      phase_in       = phase_ff;
      expect_high_in = expect_high_ff;
      upper_in       = upper_ff;
      type_in        = type_ff;
      bytes_left_in  = bytes_left_ff;
      data_left_in   = data_left_ff;
      sum_in         = sum_ff;
      shift_in       = shift_ff;
      write_in       = write_ff;
      records_in     = records_ff;
      max_in         = max_ff;
      halted_in      = halted_ff;
      if (step && item.new_file) begin
         phase_in       = PH_LINE;
         expect_high_in = 1'b1;
         upper_in       = '0;
         type_in        = '0;
         bytes_left_in  = '0;
         data_left_in   = '0;
         sum_in         = '0;
         shift_in       = '0;
         write_in       = '0;
         records_in     = '0;
         halted_in      = 1'b0;
      end else if (active) begin
         case (phase_ff)
            PH_LINE: begin
               if (is_s) begin
                  phase_in = PH_TYPE;
               end else if (!is_space) begin
                  halted_in = 1'b1;
               end
            end
            PH_TYPE: begin
               if (type_ok(item.ch)) begin
                  type_in        = item.ch[3:0];
                  phase_in       = PH_COUNT;
                  expect_high_in = 1'b1;
                  sum_in         = '0;
                  shift_in       = '0;
               end else begin
                  halted_in = 1'b1;
               end
            end
            PH_EOL: begin
               if (item.ch == CH_LF) begin
                  phase_in   = PH_LINE;
                  records_in = records_ff + COUNT_BITS'(1);
               end
            end
            PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK: begin
               if (!is_hex) begin
                  halted_in = 1'b1;
               end else if (expect_high_ff) begin
                  upper_in       = nib;
                  expect_high_in = 1'b0;
               end else begin
                  expect_high_in = 1'b1;
                  if (phase_ff == PH_COUNT) begin
                     sum_in = sum_add;
                     if (count_short) begin
                        halted_in = 1'b1;
                     end else begin
                        data_left_in = data_count;
                        shift_in     = '0;
                        if (alen != 3'd0) begin
                           phase_in      = PH_ADDR;
                           bytes_left_in = alen;
                        end else if (data_count != 8'd0) begin
                           phase_in = PH_DATA;
                        end else begin
                           phase_in = PH_CHECK;
                           sum_in   = ~sum_add;
                        end
                     end
                  end else if (phase_ff == PH_ADDR) begin
                     sum_in        = sum_add;
                     shift_in      = shift_next;
                     bytes_left_in = bytes_left_ff - 3'd1;
                     if (bytes_left_ff == 3'd1) begin
                        write_in = shift_next;
                        if (data_left_ff != 8'd0) begin
                           phase_in = PH_DATA;
                        end else begin
                           phase_in = PH_CHECK;
                           sum_in   = ~sum_add;
                        end
                     end
                  end else if (phase_ff == PH_DATA) begin
                     sum_in = sum_add;
                     if (data_type) begin
                        if (next_addr > max_ff) begin
                           max_in = next_addr;
                        end
                        write_in = next_addr[ADDRESS_BITS-1:0];
                     end
                     data_left_in = data_left_ff - 8'd1;
                     if (data_left_ff == 8'd1) begin
                        phase_in = PH_CHECK;
                        sum_in   = ~sum_add;
                     end
                  end else begin
                     phase_in = PH_EOL;
                  end
               end
            end
            default: begin
               phase_in = PH_LINE;
            end
         endcase
      end
   end

   // result of this character
   always_comb begin
      res_valid           = ev_fail | ev_write | ev_check | ev_record;
      result.kind         = KIND_WRITE;
      result.address      = '0;
      result.data         = '0;
      result.checksum_ok  = 1'b0;
      result.record_type  = type_in;
      result.record_count = records_in;
      result.high_water   = LIMIT_BITS'(max_in);
      if (ev_fail) begin
         result.kind = KIND_ERROR;
      end else if (ev_record) begin
         result.kind = KIND_RECORD;
      end else if (ev_check) begin
         result.kind        = KIND_CHECK;
         result.checksum_ok = (sum_ff == byte_v);
      end else if (ev_write) begin
         result.kind    = KIND_WRITE;
         result.address = ADDR_PORT_BITS'(write_ff);
         result.data    = byte_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_limit_ff   <= ROM_LIMIT_RESET;
         phase_ff       <= PH_LINE;
         expect_high_ff <= 1'b1;
         upper_ff       <= '0;
         type_ff        <= '0;
         bytes_left_ff  <= '0;
         data_left_ff   <= '0;
         sum_ff         <= '0;
         shift_ff       <= '0;
         write_ff       <= '0;
         records_ff     <= '0;
         max_ff         <= '0;
         halted_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            rom_limit_ff <= csr_write_data;
         end
         phase_ff       <= phase_in;
         expect_high_ff <= expect_high_in;
         upper_ff       <= upper_in;
         type_ff        <= type_in;
         bytes_left_ff  <= bytes_left_in;
         data_left_ff   <= data_left_in;
         sum_ff         <= sum_in;
         shift_ff       <= shift_in;
         write_ff       <= write_in;
         records_ff     <= records_in;
         max_ff         <= max_in;
         halted_ff      <= halted_in;
      end
   end

endmodule

`default_nettype wire

>>> src/srec_out_stage.sv
// result register of the parser: holds one response transaction until it is taken
// depends on srec_pkg
`default_nettype none

module srec_out_stage (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   load,
   input  wire srec_pkg::result_type                   result,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [1:0]                                  rsp_kind,
   output logic [srec_pkg::ADDR_PORT_BITS-1:0]         rsp_address,
   output logic [7:0]                                  rsp_data,
   output logic                                        rsp_checksum_ok,
   output logic [3:0]                                  rsp_record_type,
   output logic [srec_pkg::COUNT_BITS-1:0]             rsp_record_count,
   output logic [srec_pkg::LIMIT_BITS-1:0]             rsp_high_water
);
   import srec_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = result_ff.kind;
   assign rsp_address      = result_ff.address;
   assign rsp_data         = result_ff.data;
   assign rsp_checksum_ok  = result_ff.checksum_ok;
   assign rsp_record_type  = result_ff.record_type;
   assign rsp_record_count = result_ff.record_count;
   assign rsp_high_water   = result_ff.high_water;

endmodule

`default_nettype wire

>>> src/srec_record_parser_unit.sv
// Motorola S-record parser. Takes one text character per cycle on the req_ channel and
// gives at most one rsp_ transaction per character: a data write, a checksum verdict, a
// record completion or a format error. The character is held in an input register, is
// decoded by the parse core and lands in a result register; a new character is accepted
// every cycle unless a held response is stalled. The user must write rom_limit through
// csr_ only while the parser is idle; the block itself does not enforce this. After a
// format error nothing is returned until a transaction with req_new_file set.
// depends on srec_pkg, srec_in_stage, srec_parse_core, srec_out_stage
`default_nettype none

module srec_record_parser_unit #(
   parameter int ADDRESS_BITS = srec_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [srec_pkg::LIMIT_BITS-1:0]        csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [7:0]                             req_ch,
   input  wire logic                                   req_new_file,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [1:0]                                  rsp_kind,
   output logic [srec_pkg::ADDR_PORT_BITS-1:0]         rsp_address,
   output logic [7:0]                                  rsp_data,
   output logic                                        rsp_checksum_ok,
   output logic [3:0]                                  rsp_record_type,
   output logic [srec_pkg::COUNT_BITS-1:0]             rsp_record_count,
   output logic [srec_pkg::LIMIT_BITS-1:0]             rsp_high_water
);
   import srec_pkg::*;

   logic       in_valid;
   item_type   item;
   logic       advance;
   logic       res_valid;
   result_type result;

   assign advance = in_valid & (~rsp_valid | ~rsp_stall);

   srec_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ch       (req_ch),
      .req_new_file (req_new_file),
      .advance      (advance),
      .in_valid     (in_valid),
      .item         (item)
   );

   srec_parse_core #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_parse_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (advance),
      .item             (item),
      .res_valid        (res_valid),
      .result           (result)
   );

   srec_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (advance & res_valid),
      .result           (result),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_address      (rsp_address),
      .rsp_data         (rsp_data),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_record_type  (rsp_record_type),
      .rsp_record_count (rsp_record_count),
      .rsp_high_water   (rsp_high_water)
   );

endmodule

`default_nettype wire
